### src/assert_macros.svh
// Assertion macros for the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`endif

### src/rgtl_pkg.sv
// Package with the shared types and codes of the grid lookup.
`timescale 1ns / 1ps

package rgtl_pkg;

    localparam logic [1:0] CMD_COORD = 2'd0;
    localparam logic [1:0] CMD_NODE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] REG_X_COUNT = 2'd0;
    localparam logic [1:0] REG_Y_COUNT = 2'd1;
    localparam logic [1:0] REG_Z_COUNT = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [1:0] {
        KIND_COORD = 2'd0,
        KIND_NODE  = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [1:0]         axis;
        logic [3:0]         coord_index;
        logic [3:0]         node_x;
        logic [3:0]         node_y;
        logic [3:0]         node_z;
        logic signed [31:0] data_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
        logic signed [31:0] query_z;
    } item_t;

endpackage

### src/rgtl_front.sv
// Front end: accepts words, drops those that do nothing and queues the rest.
`timescale 1ns / 1ps

module rgtl_front
    import rgtl_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [1:0]         axis,
    input  logic [3:0]         coord_index,
    input  logic [3:0]         node_x,
    input  logic [3:0]         node_y,
    input  logic [3:0]         node_z,
    input  logic signed [31:0] data_value,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    input  logic               q_full,
    output logic               push,
    output item_t              item
);

    logic useful;
    kind_t kind;

    always_comb
    begin
        useful = 1'b0;
        kind = KIND_QUERY;
        case (command)
            CMD_COORD:
            begin
                kind = KIND_COORD;
                useful = (axis != 2'd3) && (32'(coord_index) < MAX_POINTS);
            end
            CMD_NODE:
            begin
                kind = KIND_NODE;
                useful = (32'(node_x) < MAX_POINTS) && (32'(node_y) < MAX_POINTS)
                         && (32'(node_z) < MAX_POINTS);
            end
            CMD_QUERY:
            begin
                kind = KIND_QUERY;
                useful = 1'b1;
            end
            default:
            begin
                kind = KIND_QUERY;
                useful = 1'b0;
            end
        endcase
    end

    assign in_ready = !q_full;
    assign push = in_valid && !q_full && useful;

    always_comb
    begin
        item.kind = kind;
        item.axis = axis;
        item.coord_index = coord_index;
        item.node_x = node_x;
        item.node_y = node_y;
        item.node_z = node_z;
        item.data_value = data_value;
        item.query_x = query_x;
        item.query_y = query_y;
        item.query_z = query_z;
    end

endmodule

### src/rgtl_queue.sv
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps

module rgtl_queue
    import rgtl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    item_t slot_reg [QDEPTH];
    logic [QAW-1:0] wr_reg;
    logic [QAW-1:0] rd_reg;
    logic [QAW:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == (QAW+1)'(QDEPTH));
    assign head = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### src/rgtl_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit 32 bits.
`timescale 1ns / 1ps

module rgtl_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot
);

    logic [31:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {rem_reg, low_reg[31]};
    assign diff = trial - {1'b0, den_reg};
    assign done = done_reg;
    assign quot = low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[63:32];
            low_reg <= num[31:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
                low_reg <= {low_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                low_reg <= {low_reg[30:0], 1'b0};
            end
        end
    end

endmodule

### src/rgtl_back.sv
// Back end: coordinate and node stores, cell search and interpolation sequencer.
`timescale 1ns / 1ps

module rgtl_back
    import rgtl_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  item_t               head,
    input  logic                empty,
    output logic                pop,
    input  logic [$clog2(MAX_POINTS+1)-1:0] x_count,
    input  logic [$clog2(MAX_POINTS+1)-1:0] y_count,
    input  logic [$clog2(MAX_POINTS+1)-1:0] z_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  value,
    output logic                found
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CDEPTH = 3 * MAX_POINTS;
    localparam int CAW = $clog2(CDEPTH);
    localparam int NDEPTH = MAX_POINTS * MAX_POINTS * MAX_POINTS;
    localparam int NAW = $clog2(NDEPTH);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SRD  = 9'b000000010,
        ST_SCHK = 9'b000000100,
        ST_NRD  = 9'b000001000,
        ST_NCHK = 9'b000010000,
        ST_MUL  = 9'b000100000,
        ST_DST  = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t state_reg;

    logic signed [31:0] coord_mem [CDEPTH];
    logic signed [31:0] node_mem [NDEPTH];
    logic signed [31:0] coord_rd_reg;
    logic signed [31:0] node_rd_reg;

    logic signed [31:0] qx_reg;
    logic signed [31:0] qy_reg;
    logic signed [31:0] qz_reg;
    logic [1:0]         saxis_reg;
    logic [IW-1:0]      k_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic [IW-1:0]      cell_reg [3];

    logic [2:0]         step_reg;
    logic               half_reg;
    logic signed [31:0] v1_reg;
    logic signed [31:0] v2_reg;
    logic signed [31:0] res_reg [6];
    logic [63:0]        prod_reg;
    logic [31:0]        dp_reg;
    logic               neg_reg;
    logic signed [31:0] base_reg;

    logic signed [31:0] pend_value_reg;
    logic               pend_found_reg;
    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic               found_reg;

    logic [CAW-1:0]     coord_waddr;
    logic [CAW-1:0]     coord_raddr;
    logic [NAW-1:0]     node_waddr;
    logic [NAW-1:0]     node_raddr;
    logic [NAW-1:0]     nx_idx;
    logic [NAW-1:0]     ny_idx;
    logic [NAW-1:0]     nz_idx;
    logic               y_off;
    logic               z_off;
    logic signed [31:0] sq;
    logic [CW-1:0]      scount;
    logic [CW-1:0]      k_plus;
    logic               hit;

    logic [1:0]         laxis;
    logic signed [31:0] lq;
    logic signed [31:0] lp1;
    logic signed [31:0] lp2;
    logic signed [31:0] op_v1;
    logic signed [31:0] op_v2;
    logic signed [32:0] tdiff;
    logic signed [32:0] pdiff;
    logic signed [32:0] vdiff;
    logic signed [32:0] vmag;
    logic               flat;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_quot;
    logic [63:0]        div_num;
    logic signed [32:0] sum;
    logic signed [31:0] res_val;
    logic               res_en;

    rgtl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dp_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign pop = (state_reg == ST_IDLE) && !empty;

    assign coord_waddr = CAW'(head.axis) * CAW'(MAX_POINTS) + CAW'(IW'(head.coord_index));
    assign coord_raddr = CAW'(saxis_reg) * CAW'(MAX_POINTS) + CAW'(k_reg);
    assign node_waddr = (NAW'(head.node_x) * NAW'(MAX_POINTS) + NAW'(head.node_y))
                        * NAW'(MAX_POINTS) + NAW'(head.node_z);

    assign y_off = (step_reg == 3'd1) || (step_reg == 3'd2);
    assign z_off = (step_reg == 3'd2) || (step_reg == 3'd3);
    assign nx_idx = NAW'(cell_reg[0]) + NAW'(half_reg);
    assign ny_idx = NAW'(cell_reg[1]) + NAW'(y_off);
    assign nz_idx = NAW'(cell_reg[2]) + NAW'(z_off);
    assign node_raddr = (nx_idx * NAW'(MAX_POINTS) + ny_idx) * NAW'(MAX_POINTS) + nz_idx;

    always_comb
    begin
        case (saxis_reg)
            AXIS_X:
            begin
                sq = qx_reg;
                scount = x_count;
            end
            AXIS_Y:
            begin
                sq = qy_reg;
                scount = y_count;
            end
            default:
            begin
                sq = qz_reg;
                scount = z_count;
            end
        endcase
    end

    assign k_plus = CW'(k_reg) + 1'b1;
    assign hit = (prev_reg <= sq) && (sq <= coord_rd_reg);

    always_comb
    begin
        case (step_reg)
            3'd4:
            begin
                laxis = AXIS_Y;
                op_v1 = res_reg[0];
                op_v2 = res_reg[1];
            end
            3'd5:
            begin
                laxis = AXIS_Y;
                op_v1 = res_reg[3];
                op_v2 = res_reg[2];
            end
            3'd6:
            begin
                laxis = AXIS_Z;
                op_v1 = res_reg[4];
                op_v2 = res_reg[5];
            end
            default:
            begin
                laxis = AXIS_X;
                op_v1 = v1_reg;
                op_v2 = v2_reg;
            end
        endcase
        case (laxis)
            AXIS_X:  lq = qx_reg;
            AXIS_Y:  lq = qy_reg;
            default: lq = qz_reg;
        endcase
    end

    assign lp1 = lo_reg[laxis];
    assign lp2 = hi_reg[laxis];
    assign flat = (lp2 <= lp1);
    assign tdiff = 33'(lq) - 33'(lp1);
    assign pdiff = 33'(lp2) - 33'(lp1);
    assign vdiff = 33'(op_v2) - 33'(op_v1);
    assign vmag = vdiff[32] ? -vdiff : vdiff;

    assign div_start = (state_reg == ST_DST);
    assign div_num = prod_reg + 64'(dp_reg >> 1);
    assign sum = neg_reg ? (33'(base_reg) - 33'({1'b0, div_quot}))
                         : (33'(base_reg) + 33'({1'b0, div_quot}));

    always_comb
    begin
        res_en = 1'b0;
        res_val = sum[31:0];
        if (state_reg == ST_MUL && flat)
        begin
            res_en = 1'b1;
            res_val = op_v1;
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            res_en = 1'b1;
            res_val = sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == KIND_COORD)
        begin
            coord_mem[coord_waddr] <= head.data_value;
        end
        coord_rd_reg <= coord_mem[coord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == KIND_NODE)
        begin
            node_mem[node_waddr] <= head.data_value;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == KIND_QUERY)
        begin
            qx_reg <= head.query_x;
            qy_reg <= head.query_y;
            qz_reg <= head.query_z;
        end
        if (state_reg == ST_SCHK)
        begin
            prev_reg <= coord_rd_reg;
            if (k_reg != '0 && hit)
            begin
                lo_reg[saxis_reg] <= prev_reg;
                hi_reg[saxis_reg] <= coord_rd_reg;
                cell_reg[saxis_reg] <= k_reg - 1'b1;
            end
        end
        if (state_reg == ST_NCHK)
        begin
            if (!half_reg)
            begin
                v1_reg <= node_rd_reg;
            end
            else
            begin
                v2_reg <= node_rd_reg;
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 64'(vmag[31:0]) * 64'(tdiff[31:0]);
            dp_reg <= pdiff[31:0];
            neg_reg <= vdiff[32];
            base_reg <= op_v1;
        end
        if (res_en && step_reg != 3'd6)
        begin
            res_reg[step_reg] <= res_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            saxis_reg <= AXIS_X;
            k_reg <= '0;
            step_reg <= '0;
            half_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_value_reg <= '0;
            pend_found_reg <= 1'b0;
            value_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop && head.kind == KIND_QUERY)
                    begin
                        saxis_reg <= AXIS_X;
                        k_reg <= '0;
                        state_reg <= ST_SRD;
                    end
                end
                ST_SRD:
                begin
                    state_reg <= ST_SCHK;
                end
                ST_SCHK:
                begin
                    if (k_reg == '0)
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= ST_SRD;
                    end
                    else if (hit)
                    begin
                        if (saxis_reg == AXIS_Z)
                        begin
                            step_reg <= '0;
                            half_reg <= 1'b0;
                            state_reg <= ST_NRD;
                        end
                        else
                        begin
                            saxis_reg <= saxis_reg + 1'b1;
                            k_reg <= '0;
                            state_reg <= ST_SRD;
                        end
                    end
                    else if (k_plus >= scount)
                    begin
                        pend_value_reg <= '0;
                        pend_found_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= ST_SRD;
                    end
                end
                ST_NRD:
                begin
                    state_reg <= ST_NCHK;
                end
                ST_NCHK:
                begin
                    if (!half_reg)
                    begin
                        half_reg <= 1'b1;
                        state_reg <= ST_NRD;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (!flat)
                    begin
                        state_reg <= ST_DST;
                    end
                end
                ST_DST:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        value_reg <= pend_value_reg;
                        found_reg <= pend_found_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (res_en)
            begin
                if (step_reg == 3'd6)
                begin
                    pend_value_reg <= res_val;
                    pend_found_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                    half_reg <= 1'b0;
                    if (step_reg < 3'd3)
                    begin
                        state_reg <= ST_NRD;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value = value_reg;
    assign found = found_reg;

endmodule

### src/rectilinear_grid_trilinear_lookup.sv
// Top level of the rectilinear grid trilinear lookup.
// Writes are applied in order as the back end pops them, one per cycle while it is idle.
// A query's answer time grows with the coordinates that its search scans, set by the
// single coordinate read port and the 32-step shared divider; a miss answers right
// after its search. One query at a time.
// Reset clears counts to two, the queue and the sequencer; the stores stay unwritten.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rectilinear_grid_trilinear_lookup
    import rgtl_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [1:0]         axis,
    input  logic [3:0]         coord_index,
    input  logic [3:0]         node_x,
    input  logic [3:0]         node_y,
    input  logic [3:0]         node_z,
    input  logic signed [31:0] data_value,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic               found
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] x_count_reg;
    logic [CW-1:0] y_count_reg;
    logic [CW-1:0] z_count_reg;
    logic [CW-1:0] count_next;

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t head;

    always_comb
    begin
        if (cfg_data < 5'd2)
        begin
            count_next = CW'(2);
        end
        else if (32'(cfg_data) > MAX_POINTS)
        begin
            count_next = CW'(MAX_POINTS);
        end
        else
        begin
            count_next = CW'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg <= CW'(2);
            y_count_reg <= CW'(2);
            z_count_reg <= CW'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_COUNT: x_count_reg <= count_next;
                REG_Y_COUNT: y_count_reg <= count_next;
                REG_Z_COUNT: z_count_reg <= count_next;
                default:
                begin
                end
            endcase
        end
    end

    rgtl_front #(.MAX_POINTS(MAX_POINTS)) u_front
    (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .axis        (axis),
        .coord_index (coord_index),
        .node_x      (node_x),
        .node_y      (node_y),
        .node_z      (node_z),
        .data_value  (data_value),
        .query_x     (query_x),
        .query_y     (query_y),
        .query_z     (query_z),
        .q_full      (q_full),
        .push        (push),
        .item        (push_item)
    );

    rgtl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    rgtl_back #(.MAX_POINTS(MAX_POINTS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .x_count   (x_count_reg),
        .y_count   (y_count_reg),
        .z_count   (z_count_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .found     (found)
    );

    `ASSERT_IMPLIES(a_miss_is_zero, out_valid && !found, value == 32'sd0)
    `ASSERT_IMPLIES(a_no_push_when_full, push, !q_full)
    `ASSERT_IMPLIES(a_no_pop_when_empty, pop, !q_empty)
    `ASSERT_ALWAYS(a_x_count_range, x_count_reg >= CW'(2) && 32'(x_count_reg) <= MAX_POINTS)

endmodule

### verif/rectilinear_grid_trilinear_checker.sv
// Checker that predicts grid lookup answers and compares them with the block's output.
`timescale 1ns / 1ps

module rectilinear_grid_trilinear_checker
    import rgtl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         command,
    input  logic [1:0]         axis,
    input  logic [3:0]         coord_index,
    input  logic [3:0]         node_x,
    input  logic [3:0]         node_y,
    input  logic [3:0]         node_z,
    input  logic signed [31:0] data_value,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] value,
    input  logic               found,
    output int                 fail_count,
    output int                 outstanding,
    output int                 lookups_checked,
    output int                 hits_checked
);

    typedef struct {
        logic signed [31:0] value;
        logic               found;
    } lookup_answer_t;

    logic signed [31:0] bounds [3][16];
    logic signed [31:0] grid_nodes [4096];
    int                 point_count [3];
    lookup_answer_t     expected_answers [$];

    function automatic int clamp_count(logic [4:0] raw);
        int c;
        c = raw;
        if (c < 2) c = 2;
        if (c > 16) c = 16;
        return c;
    endfunction

    function automatic int locate_bin(int ax, longint q);
        for (int p = 0; p + 1 < point_count[ax]; p++) begin
            if (longint'(bounds[ax][p]) <= q && q <= longint'(bounds[ax][p + 1]))
                return p;
        end
        return -1;
    endfunction

    function automatic longint blend(longint v1, longint v2, longint q, longint p1, longint p2);
        logic [65:0] span;
        logic [65:0] offset;
        logic [65:0] diff_mag;
        logic [65:0] step;
        longint      diff;
        if (p2 <= p1) return v1;
        span = 66'(p2 - p1);
        offset = 66'(q - p1);
        diff = v2 - v1;
        diff_mag = diff < 0 ? 66'(-diff) : 66'(diff);
        step = (diff_mag * offset + span / 2) / span;
        return diff < 0 ? v1 - longint'(step) : v1 + longint'(step);
    endfunction

    function automatic longint node_at(int i, int j, int k);
        return longint'(grid_nodes[{i[3:0], j[3:0], k[3:0]}]);
    endfunction

    function automatic lookup_answer_t predict_lookup(longint qx, longint qy, longint qz);
        lookup_answer_t ans;
        int     i, j, k;
        longint x0, x1, y0, y1, z0, z1, a0, a1, a2, a3, b0, b1;
        i = locate_bin(0, qx);
        j = locate_bin(1, qy);
        k = locate_bin(2, qz);
        ans.value = '0;
        ans.found = 1'b0;
        if (i < 0 || j < 0 || k < 0) return ans;
        x0 = bounds[0][i]; x1 = bounds[0][i + 1];
        y0 = bounds[1][j]; y1 = bounds[1][j + 1];
        z0 = bounds[2][k]; z1 = bounds[2][k + 1];
        a0 = blend(node_at(i, j, k), node_at(i + 1, j, k), qx, x0, x1);
        a1 = blend(node_at(i, j + 1, k), node_at(i + 1, j + 1, k), qx, x0, x1);
        a2 = blend(node_at(i, j + 1, k + 1), node_at(i + 1, j + 1, k + 1), qx, x0, x1);
        a3 = blend(node_at(i, j, k + 1), node_at(i + 1, j, k + 1), qx, x0, x1);
        b0 = blend(a0, a1, qy, y0, y1);
        b1 = blend(a3, a2, qy, y0, y1);
        ans.value = 32'(blend(b0, b1, qz, z0, z1));
        ans.found = 1'b1;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_answer_t want;
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++) point_count[a] = 2;
            expected_answers.delete();
            fail_count <= 0;
            outstanding <= 0;
            lookups_checked <= 0;
            hits_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_X_COUNT) point_count[0] = clamp_count(cfg_data);
                else if (cfg_index == REG_Y_COUNT) point_count[1] = clamp_count(cfg_data);
                else if (cfg_index == REG_Z_COUNT) point_count[2] = clamp_count(cfg_data);
            end
            if (in_valid && in_ready)
            begin
                if (command == CMD_COORD)
                begin
                    if (axis == AXIS_X) bounds[0][coord_index] = data_value;
                    else if (axis == AXIS_Y) bounds[1][coord_index] = data_value;
                    else if (axis == AXIS_Z) bounds[2][coord_index] = data_value;
                end
                else if (command == CMD_NODE)
                    grid_nodes[{node_x, node_y, node_z}] = data_value;
                else if (command == CMD_QUERY)
                    expected_answers.insert(expected_answers.size(),
                                            predict_lookup(query_x, query_y, query_z));
            end
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected word value=%0d found=%0b", $time, value, found);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    lookups_checked <= lookups_checked + 1;
                    if (want.found) hits_checked <= hits_checked + 1;
                    if (value !== want.value || found !== want.found)
                    begin
                        $display("%0t: mismatch expected value=%0d found=%0b, actual value=%0d found=%0b",
                                 $time, want.value, want.found, value, found);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            outstanding <= expected_answers.size();
        end
    end

endmodule

### verif/rectilinear_grid_trilinear_lookup_tb.sv
// Testbench top that drives the grid lookup and reports the verdict.
`timescale 1ns / 1ps

module rectilinear_grid_trilinear_lookup_tb;
    import rgtl_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [4:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic [1:0]         axis;
    logic [3:0]         coord_index;
    logic [3:0]         node_x;
    logic [3:0]         node_y;
    logic [3:0]         node_z;
    logic signed [31:0] data_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] value;
    logic               found;

    int fail_count;
    int outstanding;
    int lookups_checked;
    int hits_checked;

    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int idle_cycles;

    longint bound_copy [3][16];
    int     count_copy [3];
    bit     node_written [4096];

    rectilinear_grid_trilinear_lookup DUT (.*);

    rectilinear_grid_trilinear_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, nothing accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic longint random_s32();
        return longint'(signed'($urandom()));
    endfunction

    function automatic int locate_copy(int ax, longint q);
        for (int p = 0; p + 1 < count_copy[ax]; p++) begin
            if (bound_copy[ax][p] <= q && q <= bound_copy[ax][p + 1])
                return p;
        end
        return -1;
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [1:0] ax, logic [3:0] ci,
                             logic [3:0] nx, logic [3:0] ny, logic [3:0] nz,
                             longint dv, longint qx, longint qy, longint qz);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        axis        <= ax;
        coord_index <= ci;
        node_x      <= nx;
        node_y      <= ny;
        node_z      <= nz;
        data_value  <= 32'(dv);
        query_x     <= 32'(qx);
        query_y     <= 32'(qy);
        query_z     <= 32'(qz);
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_bound(int ax, int idx, longint v);
        send_word(CMD_COORD, 2'(ax), 4'(idx), 4'($urandom), 4'($urandom), 4'($urandom),
                  v, random_s32(), random_s32(), random_s32());
        bound_copy[ax][idx] = longint'(signed'(32'(v)));
    endtask

    task automatic write_node(int i, int j, int k, longint v);
        send_word(CMD_NODE, 2'($urandom), 4'($urandom), 4'(i), 4'(j), 4'(k),
                  v, random_s32(), random_s32(), random_s32());
        node_written[{i[3:0], j[3:0], k[3:0]}] = 1'b1;
    endtask

    task automatic random_node_value(output longint v);
        case ($urandom_range(0, 5))
            0: v = S32_MIN;
            1: v = S32_MAX;
            2: v = longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21);
            default: v = random_s32();
        endcase
    endtask

    task automatic run_query(longint qx, longint qy, longint qz);
        int     i, j, k;
        longint v;
        i = locate_copy(0, qx);
        j = locate_copy(1, qy);
        k = locate_copy(2, qz);
        if (i >= 0 && j >= 0 && k >= 0)
        begin
            for (int c = 0; c < 8; c++) begin
                if (!node_written[{4'(i + c[2]), 4'(j + c[1]), 4'(k + c[0])}])
                begin
                    random_node_value(v);
                    write_node(i + c[2], j + c[1], k + c[0], v);
                end
            end
        end
        send_word(CMD_QUERY, 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                  4'($urandom), random_s32(), qx, qy, qz);
    endtask

    task automatic load_axis(int ax, int style);
        longint v;
        longint gap;
        v = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        for (int i = 0; i < 16; i++) begin
            case (style)
                0, 2:
                begin
                    write_bound(ax, i, v);
                    gap = (style == 2 && $urandom_range(0, 2) == 0) ? 0
                        : longint'($urandom_range(1, 1 << 20));
                    v = (v + gap > S32_MAX) ? S32_MAX : v + gap;
                end
                1: write_bound(ax, i, S32_MIN + longint'(i) * 286331153);
                default: write_bound(ax, i, random_s32());
            endcase
        end
    endtask

    // Most points fall in the first few cells so that their corner nodes are reused.
    function automatic longint point_in_bin(int ax);
        int     p;
        int     last;
        longint lo, hi;
        last = count_copy[ax] - 2;
        if ($urandom_range(0, 15) != 0 && last > 3) last = 3;
        p = $urandom_range(0, last);
        lo = bound_copy[ax][p];
        hi = bound_copy[ax][p + 1];
        if (hi < lo) return random_s32();
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            default: return lo + longint'({$urandom(), $urandom()} % 64'(hi - lo + 1));
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_count(logic [1:0] idx, logic [4:0] raw);
        int c;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        c = raw;
        count_copy[idx] = c < 2 ? 2 : (c > 16 ? 16 : c);
    endtask

    initial
    begin
        int     r;
        int     phase;
        longint v;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_X_COUNT;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        command     <= CMD_COORD;
        axis        <= AXIS_X;
        coord_index <= '0;
        node_x      <= '0;
        node_y      <= '0;
        node_z      <= '0;
        data_value  <= '0;
        query_x     <= '0;
        query_y     <= '0;
        query_z     <= '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        for (int a = 0; a < 3; a++) count_copy[a] = 2;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int a = 0; a < 3; a++) load_axis(a, 0);

        // Directed: extreme bounds and node values, grid edges, outside points.
        write_bound(0, 0, S32_MIN);
        write_bound(0, 1, S32_MAX);
        write_node(0, 0, 0, S32_MIN);
        write_node(1, 0, 0, S32_MAX);
        run_query(S32_MIN, bound_copy[1][0], bound_copy[2][0]);
        run_query(S32_MAX, bound_copy[1][1], bound_copy[2][1]);
        run_query(0, bound_copy[1][0] + 1, bound_copy[2][1] - 1);
        run_query(1, bound_copy[1][0] - 1, bound_copy[2][0]);
        run_query(-1, bound_copy[1][0], bound_copy[2][1] + 1);
        write_bound(2, 1, bound_copy[2][0]);
        run_query(12345, bound_copy[1][1], bound_copy[2][0]);
        send_word(2'd3, AXIS_X, 4'd0, 4'd0, 4'd0, 4'd0, 0, 0, 0, 0);
        send_word(CMD_COORD, 2'd3, 4'd15, 4'd0, 4'd0, 4'd0, S32_MAX, 0, 0, 0);
        write_node(15, 15, 15, S32_MIN);
        run_query(S32_MIN, S32_MIN, S32_MIN);
        run_query(S32_MAX, S32_MAX, S32_MAX);

        for (phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0: for (int a = 0; a < 3; a++) write_count(2'(a), 5'd16);
                1: begin write_count(REG_X_COUNT, 5'd0); write_count(REG_Y_COUNT, 5'd31);
                         write_count(REG_Z_COUNT, 5'd1); end
                2: for (int a = 0; a < 3; a++) write_count(2'(a), 5'd2);
                default: for (int a = 0; a < 3; a++) write_count(2'(a), 5'($urandom));
            endcase
            for (int a = 0; a < 3; a++)
                if (phase > 0 && $urandom_range(0, 3) == 0) load_axis(a, $urandom_range(0, 3));
            case (phase % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 55; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 55; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            if (phase == 2) hold_left = 600;
            for (int n = 0; n < 35; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    run_query(point_in_bin(0), point_in_bin(1), point_in_bin(2));
                else if (r < 82)
                    run_query(random_s32(), random_s32(), random_s32());
                else if (r < 90)
                begin
                    random_node_value(v);
                    write_node($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), v);
                end
                else if (r < 95)
                begin
                    r = $urandom_range(0, 15);
                    write_bound(r % 3, r, bound_copy[r % 3][r] + $urandom_range(0, 3));
                end
                else
                    send_word($urandom_range(0, 1) ? 2'd3 : CMD_COORD, 2'd3, 4'($urandom),
                              4'($urandom), 4'($urandom), 4'($urandom), random_s32(),
                              random_s32(), random_s32(), random_s32());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d lookups (%0d inside the grid) over 8 count settings,",
                 lookups_checked, hits_checked);
        $display("with sender gaps, receiver stalls and a long output hold.");
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/rgtl_pkg.sv
src/rgtl_front.sv
src/rgtl_queue.sv
src/rgtl_div.sv
src/rgtl_back.sv
src/rectilinear_grid_trilinear_lookup.sv
verif/rectilinear_grid_trilinear_checker.sv
verif/rectilinear_grid_trilinear_lookup_tb.sv
